/* rtl/core/matrix_multiply_engine_macros.svh */
// assertion macros shared by the matrix multiply engine rtl
// expects clk and rst_n in the scope of each use
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MME_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mme assertion failed");

// next-cycle implication
`define MME_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mme assertion failed");

`else

`define MME_ASSERT_IMP(name, pre, post)
`define MME_ASSERT_NXT(name, pre, post)

`endif

`endif

/* rtl/core/mme_pkg.sv */
// shared types, constants and helper functions of the matrix multiply engine
// no dependencies
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DEPTH       = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int FIELD_IDX_W = 3;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = 35;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 48;
    localparam int IN_PAD_W    = IN_DATA_W - 2 * FIELD_IDX_W - ELEM_W;
    localparam int OUT_PAD_W   = OUT_DATA_W - 2 * FIELD_IDX_W - ACC_W;

    typedef enum logic [1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_LEN = 2'd1,
        REG_COLS_B    = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // highest loop index for a dimension register, zero acts as one
    function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (v > CFG_W'(MAX_DIM))
            r = IDX_W'(MAX_DIM - 1);
        else
            r = IDX_W'(v - 1'b1);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rc_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
    endfunction

endpackage

/* rtl/core/mme_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module mme_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/mme_mac.sv */
// shared multiply-accumulate unit: one product register, one accumulator
// depends on mme_pkg
module mme_mac import mme_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctl_t                ctl,
    input  logic signed [ELEM_W-1:0] a,
    input  logic signed [ELEM_W-1:0] b,
    output logic signed [ACC_W-1:0] acc,
    output logic                    done
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    mac_ctl_t                 ctl_reg;
    logic                     done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl;
            done_reg <= ctl_reg.valid & ctl_reg.last;
        end
    end

    always_comb
    begin
        if (ctl_reg.first)
            acc_next = ACC_W'(prod_reg);
        else
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

/* rtl/core/matrix_multiply_engine.sv */
// Matrix multiply engine C = A x B on signed Q8.8 elements with exact Q19.16
// sums. A load word (func 0 or 1) writes one element of A or B. A compute word
// (func 2) walks every result element row by row on the single shared
// multiply-accumulate unit: one term per cycle from the A and B rams, then the
// ram read, product and accumulator registers drain and the result is emitted;
// an output stall holds the emit. The input is not ready while a compute is
// running; a finished result waits in the output register while the next one
// is formed. Dimension registers of 0 act as 1, above 8 act as 8; loads beyond
// the array are dropped.
// depends on mme_pkg, mme_ram, mme_mac and matrix_multiply_engine_macros.svh
`include "matrix_multiply_engine_macros.svh"

module matrix_multiply_engine import mme_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // row_index [2:0], col_index [5:3], element_value [21:6], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func [1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_row [2:0], out_col [5:3], product_value [40:6], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic [IDX_W-1:0]        k_reg, k_next;
    logic [CFG_W-1:0]        rows_a_reg, inner_len_reg, cols_b_reg;
    logic [IDX_W-1:0]        i_last, j_last, k_last;
    mac_ctl_t                issue_ctl, rd_ctl_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [FIELD_IDX_W-1:0]  out_row_reg, out_col_reg;
    logic signed [ACC_W-1:0] out_val_reg;
    logic                    out_last_reg;
    logic                    out_load;

    logic [FIELD_IDX_W-1:0]  in_row, in_col;
    logic [ELEM_W-1:0]       in_val;
    logic                    in_range;
    logic                    s_accept;

    logic                    we_a, we_b;
    logic [ADDR_W-1:0]       waddr, raddr_a, raddr_b;
    logic [ELEM_W-1:0]       rdata_a, rdata_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_done;

    assign in_row   = s_axis_tdata[FIELD_IDX_W-1:0];
    assign in_col   = s_axis_tdata[2*FIELD_IDX_W-1:FIELD_IDX_W];
    assign in_val   = s_axis_tdata[2*FIELD_IDX_W+ELEM_W-1:2*FIELD_IDX_W];
    assign in_range = (CFG_W'(in_row) < CFG_W'(MAX_DIM)) &&
                      (CFG_W'(in_col) < CFG_W'(MAX_DIM));
    assign s_accept = s_axis_tvalid & s_axis_tready;
    assign waddr    = rc_addr(in_row[IDX_W-1:0], in_col[IDX_W-1:0]);
    assign raddr_a  = rc_addr(i_reg, k_reg);
    assign raddr_b  = rc_addr(k_reg, j_reg);

    assign i_last = dim_last(rows_a_reg);
    assign k_last = dim_last(inner_len_reg);
    assign j_last = dim_last(cols_b_reg);

    mme_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_W)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (in_val),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    mme_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_W)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (in_val),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    mme_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rd_ctl_reg),
        .a     (rdata_a),
        .b     (rdata_b),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_W'(MAX_DIM);
            inner_len_reg <= CFG_W'(MAX_DIM);
            cols_b_reg    <= CFG_W'(MAX_DIM);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_LEN: inner_len_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            rd_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            rd_ctl_reg    <= issue_ctl;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg  <= FIELD_IDX_W'(i_reg);
            out_col_reg  <= FIELD_IDX_W'(j_reg);
            out_val_reg  <= mac_acc;
            out_last_reg <= (i_reg == i_last) && (j_reg == j_last);
        end
    end

    // sequencer: one inner term per cycle in issue, then wait for the accumulator and emit
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        issue_ctl      = '0;
        s_axis_tready  = 1'b0;
        we_a           = 1'b0;
        we_b           = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        FUNC_LOAD_A:
                            we_a = in_range;
                        FUNC_LOAD_B:
                            we_b = in_range;
                        FUNC_COMPUTE:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = ST_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                issue_ctl.valid = 1'b1;
                issue_ctl.first = (k_reg == '0);
                issue_ctl.last  = (k_reg == k_last);
                if (k_reg == k_last)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load = 1'b1;
                    if ((i_reg == i_last) && (j_reg == j_last))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (j_reg == j_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_val_reg, out_col_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

    `MME_ASSERT_IMP(a_done_in_drain, mac_done, state_reg == ST_DRAIN)
    `MME_ASSERT_NXT(a_compute_starts, s_accept && (s_axis_tuser == FUNC_COMPUTE),
                    (state_reg == ST_ISSUE) && !s_axis_tready)
    `MME_ASSERT_NXT(a_emit_waits, (state_reg == ST_EMIT) && out_valid_reg && !m_axis_tready,
                    state_reg == ST_EMIT)
    `MME_ASSERT_NXT(a_no_stray_word, (state_reg != ST_EMIT) && !out_valid_reg,
                    !m_axis_tvalid)

endmodule
